// ===== rtl/coalesced_hash_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Coalesced hash table assertion macros
// Clocked, reset-gated property shorthands for the hash table unit.
// ----------------------------------------------------------------------------
`ifndef COALESCED_HASH_TABLE_UNIT_MACROS_SVH
`define COALESCED_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define CHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// Coalesced hash table package
// Request and status codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

    localparam int          SLOTS_DEFAULT    = 1024;
    localparam logic [10:0] TABLE_SIZE_RESET = 11'd1024;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SET = 2'd1;
    localparam logic [1:0] REQ_GET = 2'd2;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/cht_ifs.sv =====
// ----------------------------------------------------------------------------
// Coalesced hash table channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cht_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [31:0]        key;
    logic [31:0]        key_hash;
    logic signed [31:0] new_value;
    logic signed [31:0] default_value;

    modport source (output valid, req_type, key, key_hash, new_value, default_value,
                    input ready);
    modport sink   (input valid, req_type, key, key_hash, new_value, default_value,
                    output ready);
endinterface

interface cht_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [10:0]        count_now;

    modport source (output valid, read_value, status, count_now, input ready);
    modport sink   (input valid, read_value, status, count_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/coalesced_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// Coalesced hash table unit
// A request computes the home slot as a 32-step remainder of the key hash, reads
// that slot and then one more slot per chain link; an insert after the chain end
// runs a second 32-step remainder to the first probed slot, probes further slots
// one by one and ends in three write steps. One request in flight at a time, set
// by the read-modify-write walk over the slot memory. After reset a clearing pass
// marks every slot unused; requests wait, configuration writes pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coalesced_hash_table_unit_macros.svh"

module coalesced_hash_table_unit
    import cht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    cht_req_if.sink          req,
    cht_rsp_if.source        rsp
);

    localparam int AW  = $clog2(SLOTS);
    localparam int SZW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic          used;
        logic          has_next;
        logic [AW-1:0] link;
        logic [31:0]   key;
        logic [31:0]   value;
    } slot_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HRD, S_WALK, S_PRD, S_W1, S_W2, S_W3
    } state_t;

    slot_t mem [SLOTS];

    state_t             state_reg;
    logic [AW-1:0]      clr_reg;
    logic [10:0]        table_size_reg;
    logic [SZW-1:0]     count_reg;
    logic [SZW-1:0]     size_reg;
    logic [1:0]         rtype_reg;
    logic [31:0]        key_reg;
    logic [31:0]        nval_reg;
    logic [31:0]        dval_reg;
    logic [AW-1:0]      home_reg;
    logic [AW-1:0]      cur_reg;
    logic [AW-1:0]      p_reg;
    logic [AW-1:0]      steps_reg;
    logic [SZW-1:0]     left_reg;
    slot_t              home_word_reg;
    slot_t              cur_word_reg;
    slot_t              rd_word_reg;
    logic [31:0]        div_q_reg;
    logic [SZW-1:0]     div_r_reg;
    logic [4:0]         div_cnt_reg;
    logic               div_probe_reg;
    logic               out_valid_reg;
    logic signed [31:0] read_value_reg;
    logic [1:0]         status_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    slot_t              mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    logic [SZW-1:0]     size_in;
    logic               is_get;
    logic [31:0]        wval;
    logic [SZW:0]       trial;
    logic [SZW-1:0]     r_next;
    logic [AW-1:0]      div_res;
    logic [SZW-1:0]     p_plus;
    logic [AW-1:0]      p_wrap;
    logic               in_walk;
    logic               home_empty;
    logic               key_hit;
    logic               step_out;
    logic               follow;

    assign size_in = ({21'b0, table_size_reg} > 32'(SLOTS)) ? SZW'(SLOTS)
                                                            : SZW'(table_size_reg);
    assign is_get  = (rtype_reg >= REQ_GET);
    assign wval    = (rtype_reg == REQ_SET) ? nval_reg : 32'd0;

    assign trial   = {div_r_reg, div_q_reg[31]};
    assign r_next  = (trial >= {1'b0, size_reg}) ? SZW'(trial - {1'b0, size_reg})
                                                 : SZW'(trial);
    assign div_res = r_next[AW-1:0];

    assign p_plus  = SZW'(p_reg) + SZW'(1);
    assign p_wrap  = (p_plus == size_reg) ? '0 : p_plus[AW-1:0];

    assign in_walk    = (state_reg == S_HRD) || (state_reg == S_WALK);
    assign home_empty = (state_reg == S_HRD) && !rd_word_reg.used;
    assign key_hit    = (rd_word_reg.key == key_reg);
    assign step_out   = (steps_reg == AW'(SLOTS - 1));
    assign follow     = in_walk && !home_empty && !key_hit && rd_word_reg.has_next
                        && !step_out;

    assign req.ready      = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.count_now  = 11'(count_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = rd_word_reg;
        mem_re    = 1'b0;
        mem_raddr = div_res;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            S_DIV:
            begin
                mem_re = (div_cnt_reg == 5'd31);
            end
            S_HRD, S_WALK:
            begin
                if (home_empty)
                begin
                    mem_we    = !is_get;
                    mem_waddr = home_reg;
                    mem_wdata = '{used: 1'b1, has_next: 1'b0, link: '0,
                                  key: key_reg, value: wval};
                end
                else if (key_hit)
                begin
                    mem_we          = (rtype_reg == REQ_SET);
                    mem_wdata.value = nval_reg;
                end
                else if (follow)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_word_reg.link;
                end
            end
            S_PRD:
            begin
                mem_re    = rd_word_reg.used && (left_reg != SZW'(1));
                mem_raddr = p_wrap;
            end
            S_W1:
            begin
                mem_we             = 1'b1;
                mem_wdata          = cur_word_reg;
                mem_wdata.has_next = 1'b1;
                mem_wdata.link     = p_reg;
            end
            S_W2:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                mem_wdata = '{used: 1'b1, has_next: 1'b0, link: '0,
                              key: home_word_reg.key, value: home_word_reg.value};
            end
            S_W3:
            begin
                mem_we    = 1'b1;
                mem_waddr = home_reg;
                mem_wdata = '{used: 1'b1,
                              has_next: (cur_reg == home_reg) | home_word_reg.has_next,
                              link: (cur_reg == home_reg) ? p_reg : home_word_reg.link,
                              key: key_reg, value: wval};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_word_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            table_size_reg <= TABLE_SIZE_RESET;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready && !(req.valid && req.ready))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        rtype_reg     <= req.req_type;
                        key_reg       <= req.key;
                        nval_reg      <= req.new_value;
                        dval_reg      <= req.default_value;
                        size_reg      <= size_in;
                        div_q_reg     <= req.key_hash;
                        div_r_reg     <= '0;
                        div_cnt_reg   <= '0;
                        div_probe_reg <= 1'b0;
                        out_valid_reg <= (size_in == '0);
                        if (size_in == '0)
                        begin
                            read_value_reg <= (req.req_type >= REQ_GET) ? req.default_value
                                                                        : 32'sd0;
                            status_reg     <= ST_FULL;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    div_q_reg   <= {div_q_reg[30:0], 1'b0};
                    div_r_reg   <= r_next;
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd31)
                    begin
                        if (div_probe_reg)
                        begin
                            p_reg     <= div_res;
                            state_reg <= S_PRD;
                        end
                        else
                        begin
                            home_reg  <= div_res;
                            cur_reg   <= div_res;
                            steps_reg <= '0;
                            state_reg <= S_HRD;
                        end
                    end
                end
                S_HRD, S_WALK:
                begin
                    if (state_reg == S_HRD)
                    begin
                        home_word_reg <= rd_word_reg;
                    end
                    if (home_empty)
                    begin
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                        read_value_reg <= is_get ? dval_reg : 32'sd0;
                        status_reg     <= is_get ? ST_ABSENT : ST_INSERTED;
                        if (!is_get)
                        begin
                            count_reg <= count_reg + SZW'(1);
                        end
                    end
                    else if (key_hit)
                    begin
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                        read_value_reg <= is_get ? rd_word_reg.value : 32'sd0;
                        status_reg     <= ST_FOUND;
                    end
                    else if (!rd_word_reg.has_next)
                    begin
                        if (is_get || (size_reg == SZW'(1)))
                        begin
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                            read_value_reg <= is_get ? dval_reg : 32'sd0;
                            status_reg     <= is_get ? ST_ABSENT : ST_FULL;
                        end
                        else
                        begin
                            cur_word_reg  <= rd_word_reg;
                            left_reg      <= size_reg - SZW'(1);
                            div_q_reg     <= 32'(cur_reg) + 32'd1;
                            div_r_reg     <= '0;
                            div_cnt_reg   <= '0;
                            div_probe_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                    end
                    else if (step_out)
                    begin
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                        read_value_reg <= is_get ? dval_reg : 32'sd0;
                        status_reg     <= ST_FULL;
                    end
                    else
                    begin
                        cur_reg   <= rd_word_reg.link;
                        steps_reg <= steps_reg + AW'(1);
                        state_reg <= S_WALK;
                    end
                end
                S_PRD:
                begin
                    if (!rd_word_reg.used)
                    begin
                        state_reg <= S_W1;
                    end
                    else if (left_reg == SZW'(1))
                    begin
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                        read_value_reg <= 32'sd0;
                        status_reg     <= ST_FULL;
                    end
                    else
                    begin
                        left_reg <= left_reg - SZW'(1);
                        p_reg    <= p_wrap;
                    end
                end
                S_W1:
                begin
                    state_reg <= S_W2;
                end
                S_W2:
                begin
                    state_reg <= S_W3;
                end
                S_W3:
                begin
                    count_reg      <= count_reg + SZW'(1);
                    out_valid_reg  <= 1'b1;
                    read_value_reg <= 32'sd0;
                    status_reg     <= ST_INSERTED;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CHT_ASSERT_IMP(a_count_max, 1'b1, count_reg <= SZW'(SLOTS), "slot count above store size")
    `CHT_ASSERT_NXT(a_count_inc, state_reg == S_W3, count_reg == $past(count_reg) + SZW'(1), "insert did not count")
    `CHT_ASSERT_IMP(a_probe_range, state_reg == S_PRD, SZW'(p_reg) < size_reg, "probe slot out of range")
    `CHT_ASSERT_IMP(a_home_range, state_reg == S_WALK, SZW'(home_reg) < size_reg, "home slot out of range")

endmodule

`default_nettype wire
